// ===== hdl/fstd_pkg.sv =====
// Package for the sample to binary64 converter: format codes and the
// per-stage payload structs. No dependencies.
package fstd_pkg;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_S64 = 3'd3,
    FMT_F32 = 3'd4
  } fmt_t;

  // Stage 1 -> 2: sign and magnitude, or a finished special value.
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
    logic        special;
    logic [63:0] result;
  } s1_t;

  // Stage 2 -> 3: normalised magnitude with its top-bit position.
  typedef struct packed {
    logic        neg;
    logic [63:0] norm;
    logic [5:0]  top;
    logic        zero;
    logic        special;
    logic [63:0] result;
  } s2_t;

endpackage

// ===== hdl/fits_sample_to_double.sv =====
// Raw sample (big-endian assembled) to IEEE-754 binary64 converter.
// Depends on fstd_pkg and fstd_norm.
//
// Usage:
//   Items arrive on s_axis (tdata = sample_bits) and leave on m_axis
//   (tdata = double_bits), one result per item. The format register is
//   written through cfg_valid/cfg_ready/cfg_data; the user must write it
//   only while no item is in flight, which the block does not enforce.
//   cfg_ready is always high. Three register stages: stage 1 decodes
//   format and takes the magnitude, stage 2 finds the leading one and
//   normalises, stage 3 rounds and packs exponent and sign. An accepted
//   item passes the stage 1, 2 and 3 registers on its way to m_axis.
//   Throughput is one item per cycle unless the receiver stalls; the
//   three stages hold together when it stalls, and s_axis_tready follows
//   the output stage so a stall loses and repeats nothing.
//   Reset clears the valid bits and sets the format to u8.
module fits_sample_to_double (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,       // sample_format
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // sample_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // double_bits
);
  logic [2:0] sample_format;
  logic v1, v2, v3;
  logic adv;
  fstd_pkg::s1_t s1, s1_next;
  fstd_pkg::s2_t s2, s2_next;
  logic [63:0] s3;
  logic [63:0] s3_next;

  assign cfg_ready     = 1'b1;
  assign adv           = !v3 || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = s3;

  // Stage 1: format decode.
  always_comb begin
    logic [7:0]  fe;
    logic [22:0] fm;
    fe = s_axis_tdata[30:23];
    fm = s_axis_tdata[22:0];
    s1_next = '0;
    case (sample_format)
      fstd_pkg::FMT_U8: s1_next.mag = {56'd0, s_axis_tdata[7:0]};
      fstd_pkg::FMT_S16: begin
        s1_next.neg = s_axis_tdata[15];
        s1_next.mag = {48'd0, s_axis_tdata[15] ? 16'(-s_axis_tdata[15:0])
                                                : s_axis_tdata[15:0]};
      end
      fstd_pkg::FMT_S32: begin
        s1_next.neg = s_axis_tdata[31];
        s1_next.mag = {32'd0, s_axis_tdata[31] ? 32'(-s_axis_tdata[31:0])
                                                : s_axis_tdata[31:0]};
      end
      fstd_pkg::FMT_S64: begin
        s1_next.neg = s_axis_tdata[63];
        s1_next.mag = s_axis_tdata[63] ? -s_axis_tdata : s_axis_tdata;
      end
      fstd_pkg::FMT_F32: begin
        s1_next.neg = s_axis_tdata[31];
        if (fe == 8'hFF) begin
          // infinity passes through; force the quiet bit on a NaN, keep the payload in the top bits
          s1_next.special = 1'b1;
          s1_next.result  = {s_axis_tdata[31], 11'h7FF, fm[22] | (fm != 23'd0),
                             fm[21:0], 29'd0};
        end else if (fe == 8'd0) begin
          // subnormal: value is m * 2^-149, route through the integer path
          s1_next.special = (fm == 23'd0);
          s1_next.result  = {s_axis_tdata[31], 63'd0};
          s1_next.mag     = {41'd0, fm};
        end else begin
          s1_next.special = 1'b1;
          s1_next.result  = {s_axis_tdata[31], 11'(fe) + 11'd896, fm, 29'd0};
        end
      end
      default: s1_next.special = 1'b1;
    endcase
    // remember subnormal float for the exponent bias in stage 3
    if (sample_format == fstd_pkg::FMT_F32 && !s1_next.special)
      s1_next.result = 64'd1;
  end

  fstd_norm u_norm (.din(s1), .dout(s2_next));

  // Stage 3: round to 53 bits and pack.
  always_comb begin
    logic [52:0] keep;
    logic        rb, st;
    logic [53:0] rnd;
    logic [10:0] ex;
    keep = s2.norm[63:11];
    rb   = s2.norm[10];
    st   = |s2.norm[9:0];
    rnd  = {1'b0, keep} + 54'(rb && (st || keep[0]));
    ex   = (s2.result[0] ? 11'd873 : 11'd1022) + 11'(s2.top);
    if (s2.special)
      s3_next = s2.result;
    else if (s2.zero)
      s3_next = 64'd0;
    else
      // hidden bit and any rounding carry add into the exponent
      s3_next = {s2.neg, {ex, 52'd0} + {9'd0, rnd}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= 3'd0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (cfg_valid) sample_format <= cfg_data;
      if (adv) begin
        v1 <= s_axis_tvalid;
        v2 <= v1;
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready ##1 adv ##1 adv |=> m_axis_tvalid)
    else $error("item lost in pipeline");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("stalled while output empty");
endmodule

// ===== hdl/fstd_norm.sv =====
// Normalising stage: finds the leading one and shifts it to bit 63.
// Depends on fstd_pkg.
module fstd_norm (
  input  fstd_pkg::s1_t din,
  output fstd_pkg::s2_t dout
);
  logic [5:0] top;
  always_comb begin
    top = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (din.mag[i]) top = 6'(i);
    end
    dout.neg     = din.neg;
    dout.top     = top;
    dout.norm    = din.mag << (6'd63 - top);
    dout.zero    = (din.mag == 64'd0);
    dout.special = din.special;
    dout.result  = din.result;
  end
endmodule

// ===== test/tb.sv =====
// Testbench for fits_sample_to_double: drives raw samples in every format,
// predicts the binary64 pattern and checks each result in order.
// Depends on fstd_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // sample_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // double_bits

  logic [2:0]  fmt_now;
  logic [63:0] doubles_due[$];
  int          mismatches;
  int          checked;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;

  fits_sample_to_double u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int msb_pos(logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  // Integer magnitude to binary64, round to nearest even.
  function automatic logic [63:0] int_as_double(logic neg, logic [63:0] mag);
    int          p;
    int          sh;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] r;
    if (mag == 64'd0) return 64'd0;
    p = msb_pos(mag);
    if (p <= 52) begin
      kept = mag << (52 - p);
    end else begin
      sh   = p - 52;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      kept = mag >> sh;
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    end
    // a rounding carry ripples into the exponent
    r = (64'(p + 1022) << 52) + kept;
    r[63] = neg;
    return r;
  endfunction

  function automatic logic [63:0] single_as_double(logic [31:0] f);
    logic [63:0] sgn;
    logic [63:0] m;
    int          p;
    sgn = {f[31], 63'd0};
    m   = {41'd0, f[22:0]};
    if (f[30:23] == 8'hFF) begin
      if (m == 64'd0) return sgn | (64'h7FF << 52);
      return sgn | (64'h7FF << 52) | (64'd1 << 51) | (m << 29);
    end
    if (f[30:23] == 8'd0) begin
      if (m == 64'd0) return sgn;
      p = msb_pos(m);
      return sgn | ((64'(p + 873) << 52) + (m << (52 - p)));
    end
    return sgn | (64'(f[30:23] + 896) << 52) | (m << 29);
  endfunction

  function automatic logic [63:0] sample_as_double(logic [2:0] fmt, logic [63:0] s);
    logic [63:0] v;
    case (fmt)
      fstd_pkg::FMT_U8:  return int_as_double(1'b0, {56'd0, s[7:0]});
      fstd_pkg::FMT_S16: begin
        v = {48'd0, s[15:0]};
        return s[15] ? int_as_double(1'b1, 64'h10000 - v) : int_as_double(1'b0, v);
      end
      fstd_pkg::FMT_S32: begin
        v = {32'd0, s[31:0]};
        return s[31] ? int_as_double(1'b1, 64'h1_0000_0000 - v)
                     : int_as_double(1'b0, v);
      end
      fstd_pkg::FMT_S64: return s[63] ? int_as_double(1'b1, -s) : int_as_double(1'b0, s);
      fstd_pkg::FMT_F32: return single_as_double(s[31:0]);
      default: return 64'd0;
    endcase
  endfunction

  // Checker and receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (doubles_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          logic [63:0] want;
          want = doubles_due.pop_front();
          checked++;
          if (m_axis_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("double_bits mismatch: expected %h got %h", want, m_axis_tdata);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Keep tvalid high between back-to-back items; drop it only while idling.
  task automatic send_sample(logic [63:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    doubles_due.insert(doubles_due.size(), sample_as_double(fmt_now, s));
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (doubles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(logic [2:0] fmt);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= fmt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fmt_now = fmt;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random sample biased towards boundary and special patterns per format.
  function automatic logic [63:0] pick_sample(logic [2:0] fmt);
    logic [63:0] s;
    s = rand64();
    case ($urandom_range(7))
      0: s = s >> $urandom_range(63);
      1: s = ~(s >> $urandom_range(63));
      default: ;
    endcase
    if (fmt == fstd_pkg::FMT_F32) begin
      case ($urandom_range(5))
        0: s[30:23] = 8'hFF;
        1: s[30:23] = 8'h00;
        2: s[22:0]  = 23'd0;
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic test_directed();
    logic [63:0] edges[$];
    edges = '{64'd0, 64'hFF, 64'h7F, 64'h80, 64'h7FFF, 64'h8000, 64'hFFFF,
              64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF,
              64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h0020_0000_0000_0001,
              64'h0060_0000_0000_0003};
    for (int f = 0; f < 8; f++) begin
      write_format(3'(f));
      foreach (edges[i]) send_sample(edges[i]);
    end
    // float negative zero, subnormals, infinities, NaNs and 1.0
    write_format(fstd_pkg::FMT_F32);
    send_sample(64'h8000_0000);
    send_sample(64'h0000_0001);
    send_sample(64'h807F_FFFF);
    send_sample(64'h7F80_0000);
    send_sample(64'hFF80_0000);
    send_sample(64'h7F80_0001);
    send_sample(64'hFFFF_FFFF_FFC0_0000);
    send_sample(64'h3F80_0000);
  endtask

  task automatic test_random(int n);
    logic [2:0] fmt;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        fmt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        write_format(fmt);
      end
      send_sample(pick_sample(fmt_now));
    end
  endtask

  task automatic test_backpressure();
    write_format(fstd_pkg::FMT_S64);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_sample(pick_sample(fstd_pkg::FMT_S64));
    // hold the sender until the pipe is empty
    wait_drained();
    for (int i = 0; i < 20; i++) send_sample(pick_sample(fstd_pkg::FMT_S64));
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= 3'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 64'd0;
    fmt_now       = fstd_pkg::FMT_U8;
    mismatches    = 0;
    checked       = 0;
    cycles        = 0;
    hold_cycles   = 0;
    send_idle_pct = 33;
    recv_idle_pct = 57;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    send_idle_pct = 57;
    recv_idle_pct = 33;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);
    test_backpressure();
    wait_drained();
    $display("covered all eight format codes, integer and float edge values, random");
    $display("samples under three stall mixes, %0d results checked", checked);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fstd_pkg.sv
hdl/fstd_norm.sv
hdl/fits_sample_to_double.sv
test/tb.sv
